// File: hw/rtl/lntd_pkg.sv
// Shared types and constants for the line number table decoder.
`default_nettype none
package lntd_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NUM_CAND = 3;   // most segments one item can emit
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = 2;
  localparam int unsigned Q_CNT_W  = 3;

  localparam logic signed [WORD_W-1:0] LINE_MAX         = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] FIRST_LINE_RESET = 32'sd1;
  localparam logic [WORD_W-1:0]        CODE_LEN_RESET   = 32'd0;

  // configuration register indexes
  localparam logic REG_FIRST_LINE  = 1'b0;
  localparam logic REG_CODE_LENGTH = 1'b1;

  typedef struct packed {
    logic              last;
    logic signed [31:0] line;
    logic [31:0]        seg_end;
    logic [31:0]        seg_start;
  } seg_t;

endpackage
`default_nettype wire

// File: hw/rtl/line_number_table_decoder.sv
// Top level of the line number table decoder.
// The block reads a line table one byte per item and pairs the bytes as
// (byte increment, line increment). It keeps a wrapping 32-bit byte offset,
// the start of the open segment and the current line, which saturates to
// [0, 2^31-1]. A pair with a nonzero line increment (and a nonzero byte
// increment, except for the first such pair) closes a segment; the closed
// segment is held one step so the end of the table can stretch it to
// code_length or add a closing segment. tlast on the input ends the table
// after the item's byte; tuser = 0 marks an item with no byte (a bare end
// marker, or nothing at all without tlast). An empty table gives one segment
// (0, code_length, first_line) when code_length is nonzero; a lone trailing
// byte is dropped. The output tlast flags the last segment of a table.
// Timing: the decode state updates at the accept edge and up to three
// segments go into a four-entry result queue, which drains one segment per
// cycle while m_tready is high. s_tready is high while the queue holds at
// most one segment, so items flow at one per cycle as long as each yields at
// most one segment and the output keeps up. Registers are to be written
// through the cfg channel (always ready) only while idle; the block does
// not enforce it. Index 0 is first_line (signed), index 1 is code_length.
`default_nettype none
module line_number_table_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] table_byte
  input  wire logic        s_tuser,   // [0] byte_present
  input  wire logic        s_tlast,   // end_of_table
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // [31:0] segment_start, [63:32] segment_end,
                                      // [95:64] line_number
  output logic             m_tlast,   // final_segment
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic signed [31:0] first_line;
  logic [31:0]        code_length;
  logic               cfg_write;
  logic               first_line_wr;
  logic               in_accept;
  logic               has_room;

  lntd_pkg::seg_t [lntd_pkg::NUM_CAND-1:0] cand;
  logic [lntd_pkg::NUM_CAND-1:0]           cand_valid;
  lntd_pkg::seg_t                          out_seg;

  assign cfg_ready     = 1'b1;
  assign cfg_write     = cfg_valid && cfg_ready;
  assign first_line_wr = cfg_write && (cfg_index == lntd_pkg::REG_FIRST_LINE);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_line  <= lntd_pkg::FIRST_LINE_RESET;
      code_length <= lntd_pkg::CODE_LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lntd_pkg::REG_FIRST_LINE:  first_line  <= cfg_data;
        lntd_pkg::REG_CODE_LENGTH: code_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready  = has_room;
  assign in_accept = s_tvalid && s_tready;

  lntd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .in_accept       (in_accept),
    .table_byte      (s_tdata),
    .byte_present    (s_tuser),
    .end_of_table    (s_tlast),
    .first_line      (first_line),
    .code_length     (code_length),
    .first_line_wr   (first_line_wr),
    .first_line_data (cfg_data),
    .cand            (cand),
    .cand_valid      (cand_valid)
  );

  lntd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_seg   (cand),
    .push_valid (cand_valid & {lntd_pkg::NUM_CAND{in_accept}}),
    .has_room   (has_room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_seg    (out_seg)
  );

  assign m_tdata = {out_seg.line, out_seg.seg_end, out_seg.seg_start};
  assign m_tlast = out_seg.last;

endmodule
`default_nettype wire

// File: hw/rtl/lntd_core.sv
// Decode state and segment generation, one table item per cycle when accepted.
`default_nettype none
module lntd_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_accept,
  input  wire logic [7:0]                     table_byte,
  input  wire logic                           byte_present,
  input  wire logic                           end_of_table,
  input  wire logic signed [31:0]             first_line,
  input  wire logic [31:0]                    code_length,
  input  wire logic                           first_line_wr,
  input  wire logic signed [31:0]             first_line_data,
  output lntd_pkg::seg_t [lntd_pkg::NUM_CAND-1:0] cand,
  output logic [lntd_pkg::NUM_CAND-1:0]       cand_valid
);

  logic [7:0]         held_byte;
  logic               half_seen;
  logic               any_seen;
  logic [31:0]        offset;
  logic [31:0]        open_start;
  logic signed [31:0] line;
  logic               pend_valid;
  logic [31:0]        pend_start;
  logic [31:0]        pend_end;
  logic signed [31:0] pend_line;

  logic [7:0]         held_byte_next;
  logic               half_seen_next;
  logic               any_seen_next;
  logic [31:0]        offset_next;
  logic [31:0]        open_start_next;
  logic signed [31:0] line_next;
  logic               pend_valid_next;
  logic [31:0]        pend_start_next;
  logic [31:0]        pend_end_next;
  logic signed [31:0] pend_line_next;

  logic               pair;
  logic               line_step;
  logic               close_seg;
  logic [31:0]        pair_offset;
  logic signed [33:0] line_sum;
  logic signed [31:0] line_sat;
  logic               below_len;

  assign pair        = byte_present && half_seen;
  assign line_step   = pair && (table_byte != 8'd0);
  assign close_seg   = line_step && ((held_byte != 8'd0) || !pend_valid);
  assign pair_offset = offset + {24'd0, held_byte};
  assign line_sum    = {{2{line[31]}}, line} + {26'd0, table_byte};

  // saturate to [0, LINE_MAX]
  always_comb begin
    if (line_sum[33]) begin
      line_sat = '0;
    end else if (line_sum[32:31] != 2'b00) begin
      line_sat = lntd_pkg::LINE_MAX;
    end else begin
      line_sat = line_sum[31:0];
    end
  end

  always_comb begin
    held_byte_next  = byte_present && !half_seen ? table_byte : held_byte;
    half_seen_next  = byte_present ? !half_seen : half_seen;
    any_seen_next   = any_seen || byte_present;
    offset_next     = pair ? pair_offset : offset;
    open_start_next = close_seg ? pair_offset : open_start;
    line_next       = line_step ? line_sat : line;
    pend_valid_next = pend_valid || close_seg;
    pend_start_next = close_seg ? open_start : pend_start;
    pend_end_next   = close_seg ? pair_offset : pend_end;
    pend_line_next  = close_seg ? line : pend_line;
  end

  assign below_len = offset_next < code_length;

  always_comb begin
    // flushed held segment when a new one closes
    cand[0].seg_start = pend_start;
    cand[0].seg_end   = pend_end;
    cand[0].line      = pend_line;
    cand[0].last      = 1'b0;
    cand_valid[0]     = close_seg && pend_valid;

    // first end-of-table segment
    if (!any_seen_next) begin
      cand[1].seg_start = '0;
      cand[1].seg_end   = code_length;
      cand[1].line      = first_line;
      cand[1].last      = 1'b1;
      cand_valid[1]     = end_of_table && (code_length != '0);
    end else begin
      cand[1].seg_start = pend_start_next;
      cand[1].seg_end   = below_len ? pend_end_next : code_length;
      cand[1].line      = pend_line_next;
      cand[1].last      = !below_len;
      cand_valid[1]     = end_of_table && pend_valid_next;
    end

    // open segment closed at the code length
    cand[2].seg_start = open_start_next;
    cand[2].seg_end   = code_length;
    cand[2].line      = line_next;
    cand[2].last      = 1'b1;
    cand_valid[2]     = end_of_table && any_seen_next && (below_len || !pend_valid_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte  <= '0;
      half_seen  <= 1'b0;
      any_seen   <= 1'b0;
      offset     <= '0;
      open_start <= '0;
      line       <= lntd_pkg::FIRST_LINE_RESET;
      pend_valid <= 1'b0;
    end else if (in_accept && end_of_table) begin
      held_byte  <= '0;
      half_seen  <= 1'b0;
      any_seen   <= 1'b0;
      offset     <= '0;
      open_start <= '0;
      line       <= first_line;
      pend_valid <= 1'b0;
    end else if (in_accept) begin
      held_byte  <= held_byte_next;
      half_seen  <= half_seen_next;
      any_seen   <= any_seen_next;
      offset     <= offset_next;
      open_start <= open_start_next;
      line       <= line_next;
      pend_valid <= pend_valid_next;
    end else if (first_line_wr && !any_seen) begin
      line <= first_line_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_start <= pend_start_next;
      pend_end   <= pend_end_next;
      pend_line  <= pend_line_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lntd_queue.sv
// Small result queue that takes up to three segments per cycle and drains one while out_ready is high.
`default_nettype none
module lntd_queue (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire lntd_pkg::seg_t [lntd_pkg::NUM_CAND-1:0] push_seg,
  input  wire logic [lntd_pkg::NUM_CAND-1:0]      push_valid,
  output logic                                    has_room,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output lntd_pkg::seg_t                          out_seg
);

  lntd_pkg::seg_t entry [lntd_pkg::Q_DEPTH];

  logic [lntd_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [lntd_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [lntd_pkg::Q_CNT_W-1:0] count;
  logic [lntd_pkg::Q_CNT_W-1:0] count_next;
  logic [lntd_pkg::Q_PTR_W-1:0] wr_idx [lntd_pkg::NUM_CAND];
  logic [lntd_pkg::Q_CNT_W-1:0] n_push;
  logic                         pop;

  // candidates are packed in order: each skips past the valid ones before it
  always_comb begin
    wr_idx[0] = wr_ptr;
    wr_idx[1] = wr_ptr + {{(lntd_pkg::Q_PTR_W-1){1'b0}}, push_valid[0]};
    wr_idx[2] = wr_idx[1] + {{(lntd_pkg::Q_PTR_W-1){1'b0}}, push_valid[1]};
    n_push    = {{(lntd_pkg::Q_CNT_W-1){1'b0}}, push_valid[0]}
              + {{(lntd_pkg::Q_CNT_W-1){1'b0}}, push_valid[1]}
              + {{(lntd_pkg::Q_CNT_W-1){1'b0}}, push_valid[2]};
  end

  assign out_valid  = count != '0;
  assign pop        = out_valid && out_ready;
  assign out_seg    = entry[rd_ptr];
  assign count_next = count + n_push - {{(lntd_pkg::Q_CNT_W-1){1'b0}}, pop};
  // room for a full burst of results from the next item
  assign has_room   = count <= lntd_pkg::Q_CNT_W'(lntd_pkg::Q_DEPTH - lntd_pkg::NUM_CAND);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + {{(lntd_pkg::Q_PTR_W-1){1'b0}}, pop};
      wr_ptr <= wr_ptr + n_push[lntd_pkg::Q_PTR_W-1:0];
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < lntd_pkg::NUM_CAND; k++) begin
      if (push_valid[k]) begin
        entry[wr_idx[k]] <= push_seg[k];
      end
    end
  end

endmodule
`default_nettype wire
